// ===== src/esob_pkg.sv =====
// Shared constants and types for the enveloped sine oscillator bank.
// Used by the bank top level and its port checker; no dependencies.

package esob_pkg;

	// Bank size and sine table resolution
	localparam int CHANNELS         = 7;
	localparam int CH_W             = $clog2(CHANNELS);
	localparam int SINE_TABLE_DEPTH = 1024;
	localparam int IDX_W            = $clog2(SINE_TABLE_DEPTH);

	// Field widths of the stream items
	localparam int FUNC_W    = 3;
	localparam int DELTA_W   = 20;
	localparam int CHAN_W    = 3;
	localparam int FREQ_W    = 24;
	localparam int AMP_W     = 16;
	localparam int PHASE_W   = 16;
	localparam int OUT_CH_W  = 3;
	localparam int OFFSET_W  = 32;
	localparam int S_DATA_W  = 80;
	localparam int M_DATA_W  = 40;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_DURATION  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLEND_IN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLEND_OUT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 2'd3;
	localparam logic [15:0] SCALE_RESET = 16'd256;

	// Item kinds carried in tuser
	localparam logic [FUNC_W-1:0] FUNC_TICK  = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_START = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_SOFT  = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_HARD  = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_LOAD  = 3'd4;

	// Quarter-wave polynomial coefficients, Q16
	localparam logic [16:0] SIN_A = 17'd102944;
	localparam logic [15:0] SIN_B = 16'd42048;
	localparam logic [12:0] SIN_C = 13'd4640;

	// Keep only the angle bits that select a table entry
	localparam logic [15:0] ANGLE_MASK = 16'hFFFF << (16 - IDX_W);

	// Envelope division: one quotient bit per cycle
	localparam int DIV_STEPS = 16;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Full-scale envelope, Q16
	localparam logic [16:0] ENV_ONE = 17'h10000;

	// One entry of the channel memory
	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [AMP_W-1:0]   amplitude;
		logic [FREQ_W-1:0]  frequency;
	} chan_entry_t;

endpackage

// ===== src/enveloped_sine_oscillator_bank_unit.sv =====
// Enveloped sine oscillator bank; depends on esob_pkg, channel settings in a synchronous memory.
// Start, stop, load and silent ticks end in ST_IDLE. An emitting tick passes accept, envelope
// select, divide (ramps only), gain, and per channel read, angle, fold, square, poly C, poly B,
// sine, amp, gain and emit, where a stalled output holds it; the next item waits for the whole tick.
// Reset (arst_n low, asynchronous): bank finished, times zero, registers at defaults;
// the channel memory is not cleared, so a channel must be loaded before it is played.

module enveloped_sine_oscillator_bank_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	// delta[19:0], channel[22:20], frequency[46:23], amplitude[62:47], phase[78:63]
	input  logic [esob_pkg::S_DATA_W-1:0]   s_tdata,
	// func[2:0]
	input  logic [esob_pkg::FUNC_W-1:0]     s_tuser,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// out_channel[2:0], offset[34:3]
	output logic [esob_pkg::M_DATA_W-1:0]   m_tdata,
	output logic                            m_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic                            cfg_we,
	input  logic [esob_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [esob_pkg::CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_ENV  = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_GAIN = 5'b01000,
		ST_CHAN = 5'b10000
	} state_t;

	typedef enum logic [9:0] {
		SP_READ   = 10'b0000000001,
		SP_ANGLE  = 10'b0000000010,
		SP_FOLD   = 10'b0000000100,
		SP_SQUARE = 10'b0000001000,
		SP_POLY_C = 10'b0000010000,
		SP_POLY_B = 10'b0000100000,
		SP_SINE   = 10'b0001000000,
		SP_AMP    = 10'b0010000000,
		SP_GAIN   = 10'b0100000000,
		SP_EMIT   = 10'b1000000000
	} step_t;

	// Configuration registers
	logic [31:0] duration_q, blend_in_q, blend_out_q;
	logic [15:0] scale_q;

	// Envelope state
	logic [31:0] elapsed_q, end_time_q;
	logic        done_q;

	// Sequencer
	state_t                        state_q;
	step_t                         step_q;
	logic [esob_pkg::CH_W-1:0]     ch_q;
	logic [esob_pkg::DIV_CNT_W-1:0] div_cnt_q;

	// Datapath registers
	logic [31:0] rem_q, den_q;
	logic [15:0] quo_q;
	logic        env_full_q;
	logic [32:0] se_q;
	esob_pkg::chan_entry_t rd_q;
	logic [15:0] angp_q;
	logic [16:0] z_q, z2_q, tb_q, s_q;
	logic [15:0] t_q;
	logic        sneg_q;
	logic [32:0] sa_q, mag_q;

	// Output register
	logic                          m_valid_q;
	logic [esob_pkg::OUT_CH_W-1:0] m_ch_q;
	logic [31:0]                   m_off_q;
	logic                          m_last_q;

	// Channel memory
	esob_pkg::chan_entry_t chan_mem [esob_pkg::CHANNELS];

	// Input fields
	logic [esob_pkg::DELTA_W-1:0] in_delta;
	logic [esob_pkg::CHAN_W-1:0]  in_channel;
	esob_pkg::chan_entry_t        in_entry;
	logic                         accept;

	assign in_delta            = s_tdata[19:0];
	assign in_channel          = s_tdata[22:20];
	assign in_entry.frequency  = s_tdata[46:23];
	assign in_entry.amplitude  = s_tdata[62:47];
	assign in_entry.phase      = s_tdata[78:63];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// Saturated elapsed time for a tick
	logic [32:0] el_sum;
	logic [31:0] el_sat;
	assign el_sum = {1'b0, elapsed_q} + {13'b0, in_delta};
	assign el_sat = el_sum[32] ? 32'hFFFF_FFFF : el_sum[31:0];

	// Soft stop target
	logic [32:0] soft_end;
	assign soft_end = {1'b0, elapsed_q} + {1'b0, blend_out_q};

	// Envelope region select
	logic in_ramp, out_ramp;
	assign in_ramp  = (blend_in_q != 32'd0) && (elapsed_q < blend_in_q);
	assign out_ramp = (blend_out_q != 32'd0) && (soft_end > {1'b0, end_time_q});

	// Restoring divide step
	logic [32:0] div_sh;
	logic        div_ge;
	assign div_sh = {rem_q, 1'b0};
	assign div_ge = div_sh >= {1'b0, den_q};

	logic [16:0] env_val;
	assign env_val = env_full_q ? esob_pkg::ENV_ONE : {1'b0, quo_q};

	// Angle to folded quarter-wave position
	logic [15:0] ang, pos;
	logic [14:0] zr;
	assign ang = angp_q + rd_q.phase;
	assign pos = ang & esob_pkg::ANGLE_MASK;
	assign zr  = pos[14] ? (15'd16384 - {1'b0, pos[13:0]}) : {1'b0, pos[13:0]};

	// Polynomial products
	logic [55:0] ang_prod;
	logic [33:0] sq_prod, sine_prod;
	logic [29:0] c_prod;
	logic [32:0] b_prod;
	logic [65:0] gain_prod;
	assign ang_prod  = 56'(elapsed_q) * 56'(rd_q.frequency);
	assign sq_prod   = 34'(z_q) * 34'(z_q);
	assign c_prod    = 30'(esob_pkg::SIN_C) * 30'(z2_q);
	assign b_prod    = 33'(t_q) * 33'(z2_q);
	assign sine_prod = 34'(z_q) * 34'(tb_q);
	assign gain_prod = 66'(sa_q) * 66'(se_q);

	// Amplitude magnitude and sign
	logic        aneg;
	logic [15:0] amag;
	assign aneg = rd_q.amplitude[15];
	assign amag = aneg ? (~rd_q.amplitude + 16'd1) : rd_q.amplitude;

	// Sign and saturate the final magnitude
	logic        oneg;
	logic [31:0] off_val;
	logic [32:0] mag_neg;
	assign oneg    = sneg_q ^ aneg;
	assign mag_neg = ~mag_q + 33'd1;
	always_comb begin
		if (oneg) begin
			off_val = (mag_q > 33'h0_8000_0000) ? 32'h8000_0000 : mag_neg[31:0];
		end else begin
			off_val = (mag_q > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag_q[31:0];
		end
	end

	logic emit_go, ch_last;
	assign emit_go = (state_q == ST_CHAN) && (step_q == SP_EMIT) && (!m_valid_q || m_tready);
	assign ch_last = (ch_q == esob_pkg::CH_W'(esob_pkg::CHANNELS - 1));

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duration_q  <= '0;
			blend_in_q  <= '0;
			blend_out_q <= '0;
			scale_q     <= esob_pkg::SCALE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				esob_pkg::REG_DURATION:  duration_q  <= cfg_data;
				esob_pkg::REG_BLEND_IN:  blend_in_q  <= cfg_data;
				esob_pkg::REG_BLEND_OUT: blend_out_q <= cfg_data;
				esob_pkg::REG_SCALE:     scale_q     <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Control: item decode, envelope state and sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q  <= '0;
			end_time_q <= '0;
			done_q     <= 1'b1;
			state_q    <= ST_IDLE;
			step_q     <= SP_READ;
			ch_q       <= '0;
			div_cnt_q  <= '0;
			env_full_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (s_tuser)
							esob_pkg::FUNC_START: begin
								elapsed_q  <= '0;
								end_time_q <= duration_q;
								done_q     <= 1'b0;
							end
							esob_pkg::FUNC_SOFT: begin
								if (blend_out_q != 32'd0 && soft_end < {1'b0, end_time_q}) begin
									end_time_q <= soft_end[31:0];
								end else begin
									done_q <= 1'b1;
								end
							end
							esob_pkg::FUNC_HARD: done_q <= 1'b1;
							esob_pkg::FUNC_TICK: begin
								if (!done_q && end_time_q != 32'd0) begin
									elapsed_q <= el_sat;
									if (el_sat >= end_time_q) begin
										done_q <= 1'b1;
									end else begin
										state_q <= ST_ENV;
									end
								end
							end
							default: ;
						endcase
					end
				end
				ST_ENV: begin
					div_cnt_q <= '0;
					if (in_ramp || out_ramp) begin
						env_full_q <= 1'b0;
						state_q    <= ST_DIV;
					end else begin
						env_full_q <= 1'b1;
						state_q    <= ST_GAIN;
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + esob_pkg::DIV_CNT_W'(1);
					if (div_cnt_q == esob_pkg::DIV_CNT_W'(esob_pkg::DIV_STEPS - 1)) begin
						state_q <= ST_GAIN;
					end
				end
				ST_GAIN: begin
					ch_q    <= '0;
					step_q  <= SP_READ;
					state_q <= ST_CHAN;
				end
				ST_CHAN: begin
					case (step_q)
						SP_READ:   step_q <= SP_ANGLE;
						SP_ANGLE:  step_q <= SP_FOLD;
						SP_FOLD:   step_q <= SP_SQUARE;
						SP_SQUARE: step_q <= SP_POLY_C;
						SP_POLY_C: step_q <= SP_POLY_B;
						SP_POLY_B: step_q <= SP_SINE;
						SP_SINE:   step_q <= SP_AMP;
						SP_AMP:    step_q <= SP_GAIN;
						SP_GAIN:   step_q <= SP_EMIT;
						SP_EMIT: begin
							// Hold here while the output register is full and not being taken
							if (emit_go) begin
								step_q <= SP_READ;
								ch_q   <= ch_q + esob_pkg::CH_W'(1);
								if (ch_last) begin
									state_q <= ST_IDLE;
								end
							end
						end
						default: step_q <= SP_READ;
					endcase
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Channel memory: write on load, registered read for the channel loop
	always_ff @(posedge clk) begin
		if (accept && s_tuser == esob_pkg::FUNC_LOAD &&
		    {1'b0, in_channel} < 4'(esob_pkg::CHANNELS)) begin
			chan_mem[esob_pkg::CH_W'(in_channel)] <= in_entry;
		end
		if (state_q == ST_CHAN && step_q == SP_READ) begin
			rd_q <= chan_mem[ch_q];
		end
	end

	// Envelope divider and gain
	always_ff @(posedge clk) begin
		if (state_q == ST_ENV) begin
			quo_q <= '0;
			if (in_ramp) begin
				rem_q <= elapsed_q;
				den_q <= blend_in_q;
			end else begin
				rem_q <= end_time_q - elapsed_q;
				den_q <= blend_out_q;
			end
		end
		if (state_q == ST_DIV) begin
			rem_q <= div_ge ? 32'(div_sh - {1'b0, den_q}) : div_sh[31:0];
			quo_q <= {quo_q[14:0], div_ge};
		end
		if (state_q == ST_GAIN) begin
			se_q <= 33'(scale_q) * 33'(env_val);
		end
	end

	// Per-channel datapath, at most one product per step
	always_ff @(posedge clk) begin
		if (state_q == ST_CHAN) begin
			case (step_q)
				SP_ANGLE:  angp_q <= ang_prod[31:16];
				SP_FOLD: begin
					z_q    <= {zr, 2'b00};
					sneg_q <= pos[15];
				end
				SP_SQUARE: z2_q <= sq_prod[32:16];
				SP_POLY_C: t_q  <= esob_pkg::SIN_B - {3'b0, c_prod[28:16]};
				SP_POLY_B: tb_q <= esob_pkg::SIN_A - {1'b0, b_prod[31:16]};
				SP_SINE:   s_q  <= sine_prod[32:16];
				SP_AMP:    sa_q <= 33'(s_q) * 33'(amag);
				SP_GAIN:   mag_q <= gain_prod[64:32];
				default: ;
			endcase
		end
	end

	// Output register: load on emit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit_go) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			m_ch_q   <= esob_pkg::OUT_CH_W'(ch_q);
			m_off_q  <= off_val;
			m_last_q <= ch_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tlast  = m_last_q;
	assign m_tdata  = {5'b0, m_off_q, m_ch_q};

endmodule

// ===== src/esob_checker.sv =====
// Port-level checks for the enveloped sine oscillator bank.
// Depends on esob_pkg; bound to the top level at the end of this file.

module esob_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic [esob_pkg::M_DATA_W-1:0] m_tdata,
	input logic                          m_tlast,
	input logic                          m_tvalid,
	input logic                          m_tready
);

	// Hold a stalled result item
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result item dropped while stalled");

	a_data_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("result item changed while stalled");

	// Channel index stays inside the bank
	a_channel_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] < 3'(esob_pkg::CHANNELS))
		else $error("result item for a channel outside the bank");

	// Last marks exactly the final channel of a tick
	a_last_channel: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tlast == (m_tdata[2:0] == 3'(esob_pkg::CHANNELS - 1)))
		else $error("last flag does not match the final channel");

endmodule

bind enveloped_sine_oscillator_bank_unit esob_checker u_esob_checker (.*);

// ===== bench/tb_enveloped_sine_oscillator_bank_unit.sv =====
// Self-checking bench for the enveloped sine oscillator bank: a scoreboard class predicts
// the seven channel offsets of every emitting tick, and plain tasks drive items and configuration.
// Depends on esob_pkg and enveloped_sine_oscillator_bank_unit.

module tb_enveloped_sine_oscillator_bank_unit;
	import esob_pkg::*;

	localparam int SETTLE_CYCLES = 100;
	localparam int RANDOM_ITEMS  = 300;

	typedef struct {
		bit [OUT_CH_W-1:0] chan;
		bit [OFFSET_W-1:0] offset;
		bit                last;
	} offset_item_t;

	// Bank state mirror: predicts offsets on accepted items, checks them on the output
	class osc_bank_scoreboard;
		bit [31:0]       duration, blend_in, blend_out;
		bit [15:0]       gain;
		bit [31:0]       elapsed, end_time;
		bit              finished;
		bit [FREQ_W-1:0] freq_of[CHANNELS];
		bit [AMP_W-1:0]  amp_of[CHANNELS];
		bit [15:0]       phase_of[CHANNELS];
		offset_item_t    offsets_due[$];
		int              errors;

		function new();
			gain = SCALE_RESET;
			finished = 1'b1;
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10) begin
				$display("%s", msg);
			end
		endfunction

		function int pending();
			return offsets_due.size();
		endfunction

		function void set_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] val);
			case (idx)
				REG_DURATION:  duration = val;
				REG_BLEND_IN:  blend_in = val;
				REG_BLEND_OUT: blend_out = val;
				REG_SCALE:     gain = val[15:0];
				default: ;
			endcase
		endfunction

		// Quarter-wave polynomial at the table entry that holds this angle
		function bit [63:0] sine_mag(bit [15:0] ang, output bit neg);
			bit [63:0] z, z2, t;
			z = ang[14] ? (64'd16384 - 64'({ang[13:6], 6'b0})) : 64'({ang[13:6], 6'b0});
			z = z << 2;
			z2 = (z * z) >> 16;
			t = 64'(SIN_B) - ((64'(SIN_C) * z2) >> 16);
			t = 64'(SIN_A) - ((t * z2) >> 16);
			neg = ang[15];
			return (z * t) >> 16;
		endfunction

		// Linear ramp up, then ramp down before the end, Q16
		function bit [31:0] envelope_now();
			if (blend_in != 0 && elapsed < blend_in) begin
				return 32'((64'(elapsed) << 16) / 64'(blend_in));
			end
			if (blend_out != 0 && 33'(elapsed) + 33'(blend_out) > 33'(end_time)) begin
				return 32'((64'(end_time - elapsed) << 16) / 64'(blend_out));
			end
			return 32'h10000;
		endfunction

		function bit [31:0] predict_offset(int k, bit [31:0] env);
			bit [63:0] prod, mag, amag;
			bit [15:0] ang;
			bit        sneg, aneg;
			prod = 64'(elapsed) * 64'(freq_of[k]);
			ang = prod[31:16] + phase_of[k];
			mag = sine_mag(ang, sneg);
			aneg = amp_of[k][15];
			amag = aneg ? (64'h10000 - 64'(amp_of[k])) : 64'(amp_of[k]);
			mag = (mag * amag * 64'(gain) * 64'(env)) >> 32;
			if (sneg != aneg) begin
				return (mag > 64'h80000000) ? 32'h80000000 : 32'(64'd0 - mag);
			end
			return (mag > 64'h7FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
		endfunction

		// Apply one accepted item; return 0 when the bank ignores it
		function bit note_command(bit [FUNC_W-1:0] func, bit [S_DATA_W-1:0] data);
			bit [32:0]       sum;
			bit [31:0]       env;
			bit [CHAN_W-1:0] ch;
			ch = data[22:20];
			case (func)
				FUNC_START: begin
					elapsed = 0;
					end_time = duration;
					finished = 1'b0;
					return 1'b1;
				end
				FUNC_SOFT: begin
					sum = 33'(elapsed) + 33'(blend_out);
					if (blend_out != 0 && sum < 33'(end_time)) begin
						end_time = sum[31:0];
					end else begin
						finished = 1'b1;
					end
					return 1'b1;
				end
				FUNC_HARD: begin
					finished = 1'b1;
					return 1'b1;
				end
				FUNC_LOAD: begin
					if (ch >= CHANNELS) begin
						return 1'b0;
					end
					freq_of[ch] = data[46:23];
					amp_of[ch] = data[62:47];
					phase_of[ch] = data[78:63];
					return 1'b1;
				end
				FUNC_TICK: begin
					if (finished || end_time == 0) begin
						return 1'b0;
					end
					sum = 33'(elapsed) + 33'(data[19:0]);
					elapsed = sum[32] ? 32'hFFFFFFFF : sum[31:0];
					if (elapsed >= end_time) begin
						finished = 1'b1;
						return 1'b1;
					end
					env = envelope_now();
					for (int k = 0; k < CHANNELS; k++) begin
						offsets_due.push_back('{OUT_CH_W'(k), predict_offset(k, env),
							k == CHANNELS - 1});
					end
					return 1'b1;
				end
				default: return 1'b0;
			endcase
		endfunction

		function void check_offset(bit [OUT_CH_W-1:0] ch, bit [OFFSET_W-1:0] off, bit last);
			offset_item_t want;
			if (offsets_due.size() == 0) begin
				flag($sformatf("unexpected item: ch %0d offset %0d last %0b",
					ch, $signed(off), last));
				return;
			end
			want = offsets_due.pop_front();
			if (want.chan != ch || want.offset != off || want.last != last) begin
				flag($sformatf("offset mismatch: expected ch %0d offset %0d last %0b, got ch %0d offset %0d last %0b",
					want.chan, $signed(want.offset), want.last, ch, $signed(off), last));
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic [S_DATA_W-1:0]   s_tdata;
	logic [FUNC_W-1:0]     s_tuser;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [M_DATA_W-1:0]   m_tdata;
	logic                  m_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	osc_bank_scoreboard sb = new();
	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	int live_items;

	enveloped_sine_oscillator_bank_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	function automatic logic [S_DATA_W-1:0] pack_item(logic [DELTA_W-1:0] delta,
			logic [CHAN_W-1:0] ch, logic [FREQ_W-1:0] freq, logic [AMP_W-1:0] amp,
			logic [PHASE_W-1:0] phase);
		return {1'b0, phase, amp, freq, ch, delta};
	endfunction

	function automatic logic [S_DATA_W-1:0] random_item();
		return pack_item(20'($urandom), 3'($urandom), 24'($urandom), 16'($urandom),
			16'($urandom));
	endfunction

	// Present one item after a random gap when tx_idle is set and hold it until accepted
	task automatic send_item(input logic [FUNC_W-1:0] func, input logic [S_DATA_W-1:0] data);
		int gap;
		gap = tx_idle ? $urandom_range(0, 11) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tuser = func;
		s_tdata = data;
		s_tvalid = 1'b1;
		do @(posedge clk); while (s_tready !== 1'b1);
		if (sb.note_command(func, data)) begin
			live_items++;
		end
	endtask

	task automatic send_tick(input logic [DELTA_W-1:0] delta);
		logic [S_DATA_W-1:0] data;
		data = random_item();
		data[DELTA_W-1:0] = delta;
		send_item(FUNC_TICK, data);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic write_all(input logic [31:0] dur, input logic [31:0] bin,
			input logic [31:0] bout, input logic [15:0] gain);
		write_reg(REG_DURATION, dur);
		write_reg(REG_BLEND_IN, bin);
		write_reg(REG_BLEND_OUT, bout);
		write_reg(REG_SCALE, {16'd0, gain});
	endtask

	// Drop valid, wait for every predicted offset, then let the bank settle
	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Field extremes, every function, ramp up, full level, ramp down, stops
	task automatic run_directed();
		write_all(32'h40000, 32'h10000, 32'h10000, SCALE_RESET);
		send_item(FUNC_LOAD, pack_item(20'd0, 3'd0, 24'h000000, 16'h7FFF, 16'h0000));
		send_item(FUNC_LOAD, pack_item(20'hFFFFF, 3'd1, 24'hFFFFFF, 16'h8000, 16'hFFFF));
		send_item(FUNC_LOAD, pack_item(20'd0, 3'd2, 24'h010000, 16'hFFFF, 16'h4000));
		send_item(FUNC_LOAD, pack_item(20'd0, 3'd3, 24'h800000, 16'h0000, 16'h8000));
		send_item(FUNC_LOAD, pack_item(20'd0, 3'd4, 24'($urandom), 16'h0100, 16'hC000));
		send_item(FUNC_LOAD, pack_item(20'd0, 3'd5, 24'h00ABCD, 16'h8001, 16'h3FFF));
		send_item(FUNC_LOAD, pack_item(20'd0, 3'd6, 24'h000001, 16'h7FFF, 16'hFFC0));
		// channel seven does not exist: drop the load
		send_item(FUNC_LOAD, {S_DATA_W{1'b1}});
		send_tick(20'h10000);
		send_item(3'(FUNC_LOAD + 3'd1), random_item());
		send_item(FUNC_START, random_item());
		send_tick(20'h00000);
		send_tick(20'h08000);
		send_tick(20'h14000);
		send_tick(20'h18000);
		send_tick(20'hFFFFF);
		send_tick(20'h00001);
		send_item(FUNC_START, random_item());
		send_tick(20'h10000);
		send_item(FUNC_SOFT, random_item());
		send_tick(20'h08000);
		send_item(FUNC_SOFT, random_item());
		send_item(FUNC_START, random_item());
		send_item(FUNC_HARD, random_item());
		send_tick(20'h00100);
		drain();
	endtask

	// One configuration, then a shake with random ticks, loads, stops and noise
	task automatic run_phase(input int idx);
		logic [31:0]         dur, bin, bout, span;
		logic [15:0]         gain;
		logic [S_DATA_W-1:0] data;
		logic [FUNC_W-1:0]   func;
		int                  len, pick;
		dur = $urandom_range(32'h4000, 32'h1000000);
		bin = dur >> $urandom_range(0, 4);
		bout = dur >> $urandom_range(0, 4);
		gain = 16'($urandom);
		case (idx)
			0: begin
				dur = 32'hFFFFFFFF;
				bin = 32'hFFFFFFFF;
				bout = 32'hFFFFFFFF;
				gain = 16'hFFFF;
			end
			1: begin
				dur = 0;
				bin = 0;
				bout = 0;
				gain = 0;
			end
			2: begin
				dur = $urandom_range(1, 16);
				bin = dur;
				bout = dur;
			end
			3: begin
				bin = 0;
				bout = 32'hFFFFFFFF;
				gain = 16'hFFFF;
			end
			default: begin
				case ($urandom_range(0, 9))
					0: dur = 0;
					1: dur = 32'hFFFFFFFF;
					2: dur = $urandom_range(1, 16);
					default: ;
				endcase
				case ($urandom_range(0, 5))
					0: bin = 0;
					1: bin = 32'hFFFFFFFF;
					2: bin = $urandom;
					default: ;
				endcase
				case ($urandom_range(0, 5))
					0: bout = 0;
					1: bout = 32'hFFFFFFFF;
					2: bout = $urandom;
					default: ;
				endcase
				case ($urandom_range(0, 4))
					0: gain = 0;
					1: gain = 16'hFFFF;
					2: gain = SCALE_RESET;
					default: ;
				endcase
			end
		endcase
		tx_idle = ($urandom_range(0, 3) != 0);
		rx_idle = ($urandom_range(0, 3) != 0);
		write_all(dur, bin, bout, gain);
		send_item(FUNC_START, random_item());
		len = $urandom_range(12, 36);
		repeat (len) begin
			data = random_item();
			pick = $urandom_range(0, 99);
			span = dur >> $urandom_range(1, 4);
			if (pick < 66) begin
				func = FUNC_TICK;
				// restart a finished shake about half the time
				if (sb.finished && $urandom_range(0, 1)) begin
					func = FUNC_START;
				end
				data[DELTA_W-1:0] = (span > 32'hFFFFF) ? 20'($urandom)
					: 20'($urandom_range(0, span));
			end else if (pick < 74) begin
				func = FUNC_LOAD;
			end else if (pick < 80) begin
				func = FUNC_SOFT;
			end else if (pick < 84) begin
				func = FUNC_HARD;
			end else if (pick < 90) begin
				func = FUNC_START;
			end else if (pick < 95) begin
				func = 3'(FUNC_LOAD + 3'($urandom_range(1, 3)));
			end else begin
				func = FUNC_TICK;
			end
			send_item(func, data);
		end
		drain();
	endtask

	// Short shake at full step until it ends, no idling on either side
	task automatic run_endurance();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		write_all($urandom_range(32'h0100_0000, 32'h0180_0000),
			$urandom_range(1, 32'h0080_0000),
			$urandom_range(1, 32'h0080_0000), 16'($urandom));
		send_item(FUNC_START, random_item());
		while (!sb.finished) begin
			send_tick(20'hFFFFF - 20'($urandom_range(0, 15)));
		end
		drain();
	endtask

	// Accept results after random stalls when rx_idle is set and check them in order
	initial begin : result_sink
		int hold;
		m_tready = 1'b0;
		forever begin
			hold = rx_idle ? $urandom_range(0, 11) : 0;
			@(negedge clk);
			if (hold > 0) begin
				m_tready = 1'b0;
				repeat (hold) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			sb.check_offset(m_tdata[2:0], m_tdata[34:3], m_tlast);
		end
	end

	initial begin : watchdog
		#60_000_000;
		$display("tb_enveloped_sine_oscillator_bank_unit: done, errors");
		$finish;
	end

	initial begin : stimulus
		int phase_idx;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = FUNC_TICK;
		cfg_we = 1'b0;
		cfg_index = REG_DURATION;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		run_directed();
		live_items = 0;
		phase_idx = 0;
		while (live_items < RANDOM_ITEMS) begin
			run_phase(phase_idx);
			phase_idx++;
		end
		run_endurance();

		if (sb.pending() != 0) begin
			sb.flag($sformatf("%0d offsets never arrived", sb.pending()));
		end
		if (sb.errors == 0) begin
			$display("tb_enveloped_sine_oscillator_bank_unit: done, clean");
		end else begin
			$display("tb_enveloped_sine_oscillator_bank_unit: done, errors");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
src/esob_pkg.sv
src/enveloped_sine_oscillator_bank_unit.sv
src/esob_checker.sv
bench/tb_enveloped_sine_oscillator_bank_unit.sv
